/* design/gss_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_pkg
// Shared types and constants of the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gss_pkg;

  localparam int DATA_W  = 32;
  localparam int OP_W    = 2;
  localparam int ROW_W   = 3;
  localparam int COL_W   = 3;
  localparam int IDX_W   = 3;
  localparam int STAT_W  = 2;
  localparam int SWEEP_W = 8;
  localparam int TOL_W   = 17;
  localparam int ACC_W   = 64;
  localparam int NUM_W   = 48;
  localparam int CHG_W   = 40;
  localparam int PADDR_W = 3;

  localparam logic signed [ACC_W-1:0] NUM_LIMIT = 64'sd140737488355327;

  localparam logic [SWEEP_W-1:0] MAX_SWEEPS_RST = 8'd30;
  localparam logic [TOL_W-1:0]   TOLERANCE_RST  = 17'd7;

  typedef enum logic [OP_W-1:0] {
    OP_COEFF = 2'd0,
    OP_GUESS = 2'd1,
    OP_SOLVE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_CONVERGED = 2'd0,
    ST_NOT_CONV  = 2'd1,
    ST_ZERO_PIV  = 2'd2
  } status_t;

  localparam logic REG_MAX_SWEEPS = 1'b0;
  localparam logic REG_TOLERANCE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_DIVST,
    S_DIV,
    S_WB,
    S_CHG,
    S_CHK,
    S_EMIT
  } state_t;

endpackage

/* design/gss_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_if
// Valid/ready channels of the solver: load/solve beats in, solution beats out.
// ----------------------------------------------------------------------------
interface gss_in_if
  import gss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [ROW_W-1:0]         row;
  logic [COL_W-1:0]         col;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, op, row, col, value, input ready);
  modport sink   (input valid, op, row, col, value, output ready);
endinterface

interface gss_out_if
  import gss_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         index;
  logic signed [DATA_W-1:0] solution;
  logic [STAT_W-1:0]        status;
  logic [SWEEP_W-1:0]       sweeps_used;
  logic                     last;

  modport source (output valid, index, solution, status, sweeps_used, last, input ready);
  modport sink   (input valid, index, solution, status, sweeps_used, last, output ready);
endinterface

/* design/gss_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module gss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 30
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/gauss_seidel_solver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_solver
// Gauss-Seidel iterative solver for UNKNOWNS equations in signed Q16.16.
// ----------------------------------------------------------------------------
// Load beats (op 0 coefficient, op 1 initial guess) are taken while idle. A
// solve beat holds off the input while the sequencer runs sweeps over one
// shared 32x32 multiplier and one bit-per-cycle restoring divider: each row
// reads, multiplies and sums its coefficient terms in turn (S_RD, S_MUL,
// S_ACC), then divides by the pivot (S_DIVST, S_DIV; the division is skipped
// when the pivot is zero) and writes back (S_WB), and each sweep ends with
// the change sum and the stopping test (S_CHG, S_CHK). The UNKNOWNS solution
// beats follow, one per cycle while out_ch.ready is high; the next input beat
// is taken after the last one. Coefficients and guesses must be written
// before a solve reads them.
// ----------------------------------------------------------------------------
module gauss_seidel_solver
  import gss_pkg::*;
#(
  parameter int UNKNOWNS = 5
) (
  input  logic                     clk,
  input  logic                     rst_n,
  gss_in_if.sink                   in_ch,
  gss_out_if.source                out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [PADDR_W-1:0]       cfg_paddr,
  input  logic [DATA_W-1:0]        cfg_pwdata,
  output logic [DATA_W-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int COLS  = UNKNOWNS + 1;
  localparam int DEPTH = UNKNOWNS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(UNKNOWNS);
  localparam int CW    = $clog2(COLS);
  localparam int DCW   = $clog2(ACC_W);

  // Configuration registers
  logic [SWEEP_W-1:0] max_sweeps_r;
  logic [TOL_W-1:0]   tolerance_r;

  // Sequencer and datapath
  state_t                    state_r, state_nxt;
  logic [IW-1:0]             i_r;      // row being updated
  logic [CW-1:0]             c_r;      // column being read
  logic [IW-1:0]             k_r;      // change sum / emit index
  logic [SWEEP_W-1:0]        used_r;
  logic [SWEEP_W-1:0]        sweep_count_r;
  logic [STAT_W-1:0]         status_r;
  logic                      pivot_ok_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   prod_r;
  logic signed [DATA_W-1:0]  pivot_r;
  logic signed [DATA_W-1:0]  res_r;
  logic                      zp_r;
  logic                      neg_r;
  logic [ACC_W-1:0]          dq_r;     // dividend shifting out, quotient in
  logic [DATA_W-1:0]         rem_r;
  logic [DATA_W-1:0]         dv_r;
  logic [DCW-1:0]            dcnt_r;
  logic [CHG_W-1:0]          change_r;

  logic signed [DATA_W-1:0]  cur_r  [UNKNOWNS];
  logic signed [DATA_W-1:0]  prev_r [UNKNOWNS];

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // Shared read of the current solution
  logic [IW-1:0]            rd_idx;
  logic signed [DATA_W-1:0] cur_rd;

  logic in_fire, out_fire, cfg_wr;
  logic row_ok, col_ok;
  logic last_col, last_row, last_k;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign row_ok   = 32'(in_ch.row) < UNKNOWNS;
  assign col_ok   = 32'(in_ch.col) <= UNKNOWNS;
  assign last_col = 32'(c_r) == UNKNOWNS;
  assign last_row = 32'(i_r) == UNKNOWNS - 1;
  assign last_k   = 32'(k_r) == UNKNOWNS - 1;

  assign rd_idx = (state_r == S_MUL) ? c_r[IW-1:0] : k_r;
  assign cur_rd = cur_r[rd_idx];

  // Configuration port: always ready, decode on the word address bit
  assign cfg_pready = 1'b1;
  always_comb begin
    if (cfg_paddr[2] == REG_TOLERANCE) begin
      cfg_prdata = DATA_W'(tolerance_r);
    end else begin
      cfg_prdata = DATA_W'(max_sweeps_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sweeps_r <= MAX_SWEEPS_RST;
      tolerance_r  <= TOLERANCE_RST;
    end else if (cfg_wr && cfg_pready) begin
      if (cfg_paddr[2] == REG_MAX_SWEEPS) begin
        max_sweeps_r <= cfg_pwdata[SWEEP_W-1:0];
      end else begin
        tolerance_r <= cfg_pwdata[TOL_W-1:0];
      end
    end
  end

  // Coefficient store
  gss_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_coeff (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_ch.op == OP_SOLVE) begin
          state_nxt = (max_sweeps_r == '0) ? S_EMIT : S_RD;
        end
      end
      S_RD:    state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ACC;
      S_ACC:   state_nxt = last_col ? S_DIVST : S_RD;
      S_DIVST: state_nxt = (pivot_r == '0) ? S_WB : S_DIV;
      S_DIV:   state_nxt = (dcnt_r == DCW'(ACC_W - 1)) ? S_WB : S_DIV;
      S_WB:    state_nxt = last_row ? S_CHG : S_RD;
      S_CHG:   state_nxt = last_k ? S_CHK : S_CHG;
      S_CHK: begin
        if (!pivot_ok_r || change_r < CHG_W'(tolerance_r) || used_r >= max_sweeps_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_EMIT: begin
        if (out_fire && last_k) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ch.ready        = (state_r == S_IDLE);
    out_ch.valid       = (state_r == S_EMIT);
    out_ch.index       = IDX_W'(k_r);
    out_ch.solution    = cur_rd;
    out_ch.status      = status_r;
    out_ch.sweeps_used = sweep_count_r;
    out_ch.last        = last_k;
    ram_we             = in_fire && in_ch.op == OP_COEFF && row_ok && col_ok;
    ram_waddr          = AW'(32'(in_ch.row) * COLS + 32'(in_ch.col));
    ram_raddr          = AW'(32'(i_r) * COLS + 32'(c_r));
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sweep_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHK && state_nxt == S_EMIT) begin
        sweep_count_r <= used_r;
      end else if (state_r == S_IDLE && state_nxt == S_EMIT) begin
        sweep_count_r <= '0;
      end
    end
  end

  // Datapath
  logic [DATA_W:0]          rem_sh;
  logic signed [DATA_W:0]   diff;
  logic [DATA_W:0]          diff_abs;
  logic signed [NUM_W-1:0]  num_c;
  logic [NUM_W-1:0]         num_abs;
  logic [ACC_W-1:0]         q;

  always_comb begin
    rem_sh   = {rem_r, dq_r[ACC_W-1]};
    diff     = (DATA_W+1)'(cur_rd) - (DATA_W+1)'(prev_r[k_r]);
    diff_abs = diff[DATA_W] ? (DATA_W+1)'(-diff) : diff;
    if (acc_r > NUM_LIMIT) begin
      num_c = NUM_LIMIT[NUM_W-1:0];
    end else if (acc_r < -NUM_LIMIT) begin
      num_c = NUM_W'(-NUM_LIMIT);
    end else begin
      num_c = acc_r[NUM_W-1:0];
    end
    num_abs = num_c[NUM_W-1] ? NUM_W'(-num_c) : num_c;
    q       = dq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_ok_r <= 1'b1;
      status_r   <= ST_NOT_CONV;
      used_r     <= '0;
      i_r        <= '0;
      c_r        <= '0;
      k_r        <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_fire && in_ch.op == OP_GUESS && row_ok) begin
            cur_r[in_ch.row[IW-1:0]]  <= in_ch.value;
            prev_r[in_ch.row[IW-1:0]] <= in_ch.value;
          end
          if (in_fire && in_ch.op == OP_SOLVE) begin
            i_r        <= '0;
            c_r        <= '0;
            k_r        <= '0;
            acc_r      <= '0;
            pivot_ok_r <= 1'b1;
            status_r   <= ST_NOT_CONV;
            used_r     <= (max_sweeps_r == '0) ? '0 : SWEEP_W'(1);
          end
        end
        S_MUL: begin
          // RAM data for column c is valid now
          if (last_col) begin
            acc_r <= acc_r + ACC_W'($signed(ram_rdata));
          end else if (c_r[IW-1:0] == i_r) begin
            pivot_r <= $signed(ram_rdata);
          end
          prod_r <= ACC_W'($signed(ram_rdata)) * ACC_W'(cur_rd);
        end
        S_ACC: begin
          // floor to Q16.16 by arithmetic shift
          if (!last_col && c_r[IW-1:0] != i_r) begin
            acc_r <= acc_r - (prod_r >>> 16);
          end
          if (!last_col) begin
            c_r <= c_r + CW'(1);
          end
        end
        S_DIVST: begin
          zp_r   <= (pivot_r == '0);
          neg_r  <= num_c[NUM_W-1] ^ pivot_r[DATA_W-1];
          dq_r   <= ACC_W'(num_abs) << 16;
          dv_r   <= pivot_r[DATA_W-1] ? DATA_W'(-pivot_r) : pivot_r;
          rem_r  <= '0;
          dcnt_r <= '0;
          if (num_c > 0) begin
            res_r <= {1'b0, {(DATA_W-1){1'b1}}};
          end else if (num_c < 0) begin
            res_r <= {1'b1, {(DATA_W-1){1'b0}}};
          end else begin
            res_r <= '0;
          end
          if (pivot_r == '0) begin
            pivot_ok_r <= 1'b0;
          end
        end
        S_DIV: begin
          if (rem_sh >= {1'b0, dv_r}) begin
            rem_r <= DATA_W'(rem_sh - {1'b0, dv_r});
            dq_r  <= {dq_r[ACC_W-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh[DATA_W-1:0];
            dq_r  <= {dq_r[ACC_W-2:0], 1'b0};
          end
          dcnt_r <= dcnt_r + DCW'(1);
        end
        S_WB: begin
          if (zp_r) begin
            cur_r[i_r] <= res_r;
          end else if (!neg_r) begin
            cur_r[i_r] <= (q > ACC_W'(32'h7fff_ffff)) ? {1'b0, {(DATA_W-1){1'b1}}}
                                                       : DATA_W'(q);
          end else begin
            cur_r[i_r] <= (q > ACC_W'(33'h0_8000_0000)) ? {1'b1, {(DATA_W-1){1'b0}}}
                                                         : DATA_W'(-q);
          end
          c_r      <= '0;
          acc_r    <= '0;
          k_r      <= '0;
          change_r <= '0;
          if (!last_row) begin
            i_r <= i_r + IW'(1);
          end
        end
        S_CHG: begin
          change_r    <= change_r + CHG_W'(diff_abs);
          prev_r[k_r] <= cur_rd;
          if (!last_k) begin
            k_r <= k_r + IW'(1);
          end
        end
        S_CHK: begin
          k_r <= '0;
          if (!pivot_ok_r) begin
            status_r <= ST_ZERO_PIV;
          end else if (change_r < CHG_W'(tolerance_r)) begin
            status_r <= ST_CONVERGED;
          end else if (used_r < max_sweeps_r) begin
            used_r     <= used_r + SWEEP_W'(1);
            pivot_ok_r <= 1'b1;
            i_r        <= '0;
            c_r        <= '0;
            acc_r      <= '0;
          end else begin
            status_r <= ST_NOT_CONV;
          end
        end
        S_EMIT: begin
          if (out_fire && !last_k) begin
            k_r <= k_r + IW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/gss_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gss_checker
// Port-level checks of the solver's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module gss_checker
  import gss_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_solution,
  input logic [STAT_W-1:0]        out_status,
  input logic [SWEEP_W-1:0]       out_sweeps_used,
  input logic                     out_last
);

  // Hold a stalled beat
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_solution))
    else $error("stalled solution beat changed");

  // No input while results drain
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready during result stream");

  // Run ends after the last beat
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("beat after last");

  // Status and sweep count shared by every beat of a run
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && $stable(out_status) && $stable(out_sweeps_used))
    else $error("run broken or status changed mid-run");

endmodule

bind gauss_seidel_solver gss_checker u_gss_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_solution    (out_ch.solution),
  .out_status      (out_ch.status),
  .out_sweeps_used (out_ch.sweeps_used),
  .out_last        (out_ch.last)
);

/* verif/gauss_seidel_solver_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_solver_tb
// Self-checking bench for the Gauss-Seidel solver: loads systems, runs solves
// under several sweep limits and tolerances, and compares every solution beat
// against a cycle-free Q16.16 solver kept alongside the block.
// ----------------------------------------------------------------------------
module gauss_seidel_solver_tb;
  import gss_pkg::*;

  localparam int N        = 5;
  localparam int COLS     = N + 1;
  localparam int SETTLE   = 16;     // cycles for a load beat to land before a register write
  localparam int HOLD_OFF = 400;    // one long receiver stall

  logic clk;
  logic rst_n;

  gss_in_if  beat_in ();
  gss_out_if beat_out ();

  logic               cfg_psel, cfg_penable, cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0]  cfg_pwdata, cfg_prdata;
  logic               cfg_pready;

  gauss_seidel_solver #(.UNKNOWNS(N)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (beat_in.sink),
    .out_ch     (beat_out.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // one solution beat as the block should send it
  typedef struct {
    logic [IDX_W-1:0]         index;
    logic signed [DATA_W-1:0] solution;
    status_t                  status;
    logic [SWEEP_W-1:0]       sweeps;
    logic                     last;
  } sol_beat_t;

  // directed row: payload, plus status and sweep count where they are obvious
  typedef struct {
    op_t                      op;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic signed [DATA_W-1:0] value;
    bit                       typed;
    status_t                  t_status;
    logic [SWEEP_W-1:0]       t_sweeps;
  } stim_row_t;

  // solver mirror: store, iterates and registers
  logic signed [DATA_W-1:0] a_store [N][COLS];
  logic signed [DATA_W-1:0] x_cur [N];
  logic signed [DATA_W-1:0] x_prev [N];
  logic [SWEEP_W-1:0]       lim_sweeps;
  logic [TOL_W-1:0]         lim_tol;

  sol_beat_t sol_expected [$];

  int  err_cnt;
  int  beats_sent;
  int  solves_seen;
  int  sol_beats_seen;
  bit  steady;       // no idling on either side
  bit  hold_go;      // arm the long receiver stall
  bit  hold_done;
  int  hold_left;
  bit  typed_armed;
  status_t            typed_status;
  logic [SWEEP_W-1:0] typed_sweeps;

  // --------------------------------------------------------------------------
  // Clock and reset
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Mirror of the block's arithmetic
  // --------------------------------------------------------------------------
  function automatic logic signed [DATA_W-1:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // run the sweeps and queue the N beats that the solve owes
  function automatic void solve_system();
    longint    num, piv, chg, d;
    int        used;
    bit        piv_ok;
    status_t   st;
    sol_beat_t b;
    st   = ST_NOT_CONV;
    used = 0;
    while (used < lim_sweeps) begin
      piv_ok = 1'b1;
      used++;
      for (int i = 0; i < N; i++) begin
        num = longint'(a_store[i][N]);
        piv = longint'(a_store[i][i]);
        for (int j = 0; j < N; j++)
          if (j != i)
            num -= (longint'(a_store[i][j]) * longint'(x_cur[j])) >>> 16;  // floor
        if (num > NUM_LIMIT)  num = NUM_LIMIT;
        if (num < -NUM_LIMIT) num = -NUM_LIMIT;
        if (piv == 0) begin
          // saturate towards the numerator's sign, finish the sweep regardless
          x_cur[i] = (num > 0) ? 32'sh7fffffff : ((num < 0) ? 32'sh80000000 : 32'sh0);
          piv_ok   = 1'b0;
        end else begin
          x_cur[i] = clip32((num * 65536) / piv);
        end
      end
      chg = 0;
      for (int i = 0; i < N; i++) begin
        d = longint'(x_cur[i]) - longint'(x_prev[i]);
        chg += (d < 0) ? -d : d;
        x_prev[i] = x_cur[i];
      end
      if (!piv_ok) begin
        st = ST_ZERO_PIV;
        break;
      end
      if (chg < longint'(lim_tol)) begin
        st = ST_CONVERGED;
        break;
      end
    end
    for (int i = 0; i < N; i++) begin
      b.index    = i[IDX_W-1:0];
      b.solution = x_cur[i];
      b.status   = typed_armed ? typed_status : st;
      b.sweeps   = typed_armed ? typed_sweeps : used[SWEEP_W-1:0];
      b.last     = (i == N - 1);
      sol_expected.push_back(b);
    end
    typed_armed = 1'b0;
  endfunction

  // update the mirror on every accepted input beat
  always @(posedge clk) begin
    if (rst_n && beat_in.valid && beat_in.ready) begin
      case (op_t'(beat_in.op))
        OP_COEFF: begin
          if (beat_in.row < N && beat_in.col <= N)
            a_store[beat_in.row][beat_in.col] = beat_in.value;
        end
        OP_GUESS: begin
          if (beat_in.row < N) begin
            x_cur[beat_in.row]  = beat_in.value;
            x_prev[beat_in.row] = beat_in.value;
          end
        end
        OP_SOLVE: begin
          solves_seen++;
          solve_system();
        end
        default: ;  // no-op beat: drop
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, a quiet stretch and one long hold-off
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      beat_out.ready <= 1'b0;
      hold_left      <= 0;
      hold_done      <= 1'b0;
    end else if (hold_left != 0) begin
      beat_out.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_go && !hold_done && beat_out.valid) begin
      // start the stall once results are waiting, so the input backs up
      beat_out.ready <= 1'b0;
      hold_left      <= HOLD_OFF;
      hold_done      <= 1'b1;
    end else begin
      beat_out.ready <= steady || ($urandom_range(99) >= 27);
    end
  end

  // compare each solution beat with the oldest expectation
  always @(posedge clk) begin
    sol_beat_t e;
    if (rst_n && beat_out.valid && beat_out.ready) begin
      sol_beats_seen++;
      if (sol_expected.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected solution beat index %0d value %0d", $time,
                 beat_out.index, beat_out.solution);
      end else begin
        e = sol_expected.pop_front();
        if (beat_out.index !== e.index) begin
          err_cnt++;
          $display("%0t: index exp %0d got %0d", $time, e.index, beat_out.index);
        end
        if (beat_out.solution !== e.solution) begin
          err_cnt++;
          $display("%0t: solution[%0d] exp %0d got %0d", $time, e.index,
                   e.solution, beat_out.solution);
        end
        if (beat_out.status !== e.status) begin
          err_cnt++;
          $display("%0t: status[%0d] exp %0d got %0d", $time, e.index,
                   e.status, beat_out.status);
        end
        if (beat_out.sweeps_used !== e.sweeps) begin
          err_cnt++;
          $display("%0t: sweeps_used[%0d] exp %0d got %0d", $time, e.index,
                   e.sweeps, beat_out.sweeps_used);
        end
        if (beat_out.last !== e.last) begin
          err_cnt++;
          $display("%0t: last[%0d] exp %0d got %0d", $time, e.index,
                   e.last, beat_out.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register access
  // --------------------------------------------------------------------------
  // offer one beat, idling first at random; leaves valid high after acceptance
  task automatic send_beat(op_t op, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic signed [DATA_W-1:0] value);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 27) gap = $urandom_range(4, 1);
    if (gap != 0) begin
      beat_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    beat_in.valid <= 1'b1;
    beat_in.op    <= op;
    beat_in.row   <= row;
    beat_in.col   <= col;
    beat_in.value <= value;
    @(posedge clk);
    while (!beat_in.ready) @(posedge clk);
    beats_sent++;
  endtask

  // hold the input low and wait for every owed beat, then let loads land
  task automatic drain();
    beat_in.valid <= 1'b0;
    @(posedge clk);
    while (sol_expected.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // write a register, then read it back
  task automatic reg_write(logic idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] mask;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'(idx) << 2;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_MAX_SWEEPS) begin
      lim_sweeps = data[SWEEP_W-1:0];
      mask       = 32'hff;
    end else begin
      lim_tol = data[TOL_W-1:0];
      mask    = 32'h1ffff;
    end
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if ((cfg_prdata & mask) !== (data & mask)) begin
      err_cnt++;
      $display("%0t: register %0d readback exp %0h got %0h", $time, idx,
               data & mask, cfg_prdata & mask);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // diagonally dominant content: quick convergence with random values
  function automatic logic signed [DATA_W-1:0] dominant_coeff(int i, int j);
    if (j == N) return $signed($urandom_range(13107200)) - 32'sd6553600;
    if (i == j) begin
      if ($urandom_range(15) == 0) return 32'sh0;   // now and then a zero pivot
      return $urandom_range(1) ? $signed($urandom_range(262144, 65536))
                               : -$signed($urandom_range(262144, 65536));
    end
    return $signed($urandom_range(26214)) - 32'sd13107;
  endfunction

  stim_row_t dir_rows [$];
  int phase_items [5] = '{90, 16, 90, 90, 100};
  logic [SWEEP_W-1:0] phase_sweeps [5] = '{8'd1, 8'd255, 8'd0, 8'd12, 8'd255};
  logic [TOL_W-1:0]   phase_tol [5]    = '{17'd65536, 17'd0, 17'd100, 17'd1000, 17'd7};

  initial begin
    int  stop_at, pick, r, c, cnt;
    bit  dirty;
    err_cnt = 0; beats_sent = 0; solves_seen = 0; sol_beats_seen = 0;
    steady = 1'b0; hold_go = 1'b0; typed_armed = 1'b0;
    typed_status = ST_CONVERGED; typed_sweeps = '0;
    lim_sweeps = MAX_SWEEPS_RST;
    lim_tol    = TOLERANCE_RST;
    foreach (a_store[i, j]) a_store[i][j] = '0;
    foreach (x_cur[i]) begin
      x_cur[i]  = '0;
      x_prev[i] = '0;
    end
    rst_n = 1'b0;
    beat_in.valid <= 1'b0;
    beat_in.op    <= OP_COEFF;
    beat_in.row   <= '0;
    beat_in.col   <= '0;
    beat_in.value <= '0;
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    cfg_paddr <= '0; cfg_pwdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // identity system with zero right-hand sides
    for (int i = 0; i < N; i++)
      for (int j = 0; j <= N; j++)
        send_beat(OP_COEFF, ROW_W'(i), COL_W'(j), (i == j) ? 32'sh10000 : 32'sh0);

    // directed table, reset register values
    dir_rows = '{
      '{OP_GUESS, 0, 0, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_GUESS, 1, 0, 32'sh80000000, 0, ST_CONVERGED, 0},
      '{OP_GUESS, 2, 0, 32'sh0,        0, ST_CONVERGED, 0},
      '{OP_GUESS, 3, 0, 32'sh1,        0, ST_CONVERGED, 0},
      '{OP_GUESS, 4, 0, -32'sh1,       0, ST_CONVERGED, 0},
      '{OP_COEFF, 0, N, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_COEFF, 1, N, 32'sh80000000, 0, ST_CONVERGED, 0},
      // identity: first sweep lands on b exactly, two units away from the guesses
      '{OP_SOLVE, 0, 0, 32'sh0,        1, ST_CONVERGED, 1},
      // ignored: op 3 and out-of-range row or column
      '{OP_NONE,  7, 7, 32'sh5a5a5a5a, 0, ST_CONVERGED, 0},
      '{OP_COEFF, 5, 0, 32'sh12345678, 0, ST_CONVERGED, 0},
      '{OP_COEFF, 7, 7, -32'sh1,       0, ST_CONVERGED, 0},
      '{OP_COEFF, 0, 6, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_GUESS, 5, 0, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_GUESS, 7, 7, 32'sh80000000, 0, ST_CONVERGED, 0},
      // zero pivot stops after the first sweep
      '{OP_COEFF, 2, 2, 32'sh0,        0, ST_CONVERGED, 0},
      '{OP_SOLVE, 3, 5, -32'sh1,       1, ST_ZERO_PIV,  1},
      '{OP_COEFF, 2, 2, 32'sh10000,    0, ST_CONVERGED, 0},
      // extreme off-diagonal coefficients, saturating numerators
      '{OP_COEFF, 0, 1, 32'sh80000000, 0, ST_CONVERGED, 0},
      '{OP_COEFF, 3, 4, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_GUESS, 4, 0, 32'sh7fffffff, 0, ST_CONVERGED, 0},
      '{OP_SOLVE, 0, 0, 32'sh0,        0, ST_CONVERGED, 0}
    };
    foreach (dir_rows[k]) begin
      if (dir_rows[k].typed) begin
        // wait for the mirror to catch up before arming the typed values
        drain();
        typed_armed  = 1'b1;
        typed_status = dir_rows[k].t_status;
        typed_sweeps = dir_rows[k].t_sweeps;
      end
      send_beat(dir_rows[k].op, dir_rows[k].row, dir_rows[k].col, dir_rows[k].value);
    end
    dirty = 1'b1;

    // random part, one register setting per phase
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      reg_write(REG_MAX_SWEEPS, 32'(phase_sweeps[ph]));
      reg_write(REG_TOLERANCE, 32'(phase_tol[ph]));
      steady  = (ph == 2);
      hold_go = (ph == 3);
      stop_at = beats_sent + phase_items[ph];
      while (beats_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          // well-formed: reload or patch the system, maybe new guesses, solve
          if (dirty) begin
            for (int i = 0; i < N; i++)
              for (int j = 0; j <= N; j++)
                send_beat(OP_COEFF, ROW_W'(i), COL_W'(j), dominant_coeff(i, j));
            dirty = 1'b0;
          end else begin
            cnt = $urandom_range(4);
            repeat (cnt) begin
              r = $urandom_range(N - 1);
              c = $urandom_range(N);
              send_beat(OP_COEFF, ROW_W'(r), COL_W'(c), dominant_coeff(r, c));
            end
          end
          if ($urandom_range(1))
            for (int i = 0; i < N; i++)
              send_beat(OP_GUESS, ROW_W'(i), COL_W'($urandom),
                        $signed($urandom_range(6553600)) - 32'sd3276800);
          send_beat(OP_SOLVE, ROW_W'($urandom), COL_W'($urandom), $urandom);
        end else if (pick < 95) begin
          // noise: any op but solve, any fields
          r = $urandom_range(7);
          c = $urandom_range(7);
          case ($urandom_range(2))
            0: begin
              send_beat(OP_COEFF, ROW_W'(r), COL_W'(c), $urandom);
              if (r < N && c <= N) dirty = 1'b1;
            end
            1: send_beat(OP_GUESS, ROW_W'(r), COL_W'(c), $urandom);
            default: send_beat(OP_NONE, ROW_W'(r), COL_W'(c), $urandom);
          endcase
        end else if (phase_sweeps[ph] <= 30) begin
          // broken sequence: solve whatever the store holds
          send_beat(OP_SOLVE, ROW_W'($urandom), COL_W'($urandom), $urandom);
        end
      end
    end

    // tail: every owed beat, then a short settle
    drain();
    repeat (64) @(posedge clk);
    $display("Covered %0d input beats, %0d solves, %0d solution beats,", beats_sent,
             solves_seen, sol_beats_seen);
    $display("sweep limits 0..255, tolerances 0..65536, with a long receiver stall.");
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // guard against a hung handshake
  initial begin
    #200000000;
    $display("%0t: timeout, %0d beats still owed", $time, sol_expected.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/gss_pkg.sv
design/gss_if.sv
design/gss_ram.sv
design/gauss_seidel_solver.sv
design/gss_checker.sv
verif/gauss_seidel_solver_tb.sv
